[rtl/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Request and result types and fixed field widths shared by the allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int HEAP_BYTES         = 8192;
	localparam int GRANULE_BYTES      = 8;
	localparam int REQ_W              = 16;
	localparam int OFFSET_W           = 13;
	localparam int FREE_W             = 14;
	localparam int SPLIT_MIN_GRANULES = 2;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef struct packed {
		logic                req_type;
		logic [REQ_W-1:0]    request_bytes;
		logic [OFFSET_W-1:0] payload_offset;
	} req_t;

	typedef struct packed {
		logic                ok;
		logic [OFFSET_W-1:0] granted_offset;
		logic [FREE_W-1:0]   free_bytes;
	} res_t;

endpackage

[rtl/ffha_mem.sv]
// ----------------------------------------------------------------------------
// Block header memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ffha_mem #(
	parameter int AW = 10,
	parameter int DW = 22
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/first_fit_heap_allocator_top.sv]
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Address-ordered free list with one-granule headers, split and coalescing.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// on result for exactly one cycle with done high and cannot be held off.
// After reset the block is busy while it clears all HEAP_BYTES/GRANULE_BYTES
// header entries (1024 by default). Each request walks the free list through
// the single header memory, and a malformed free offset answers in the cycle
// right after it is taken, with busy staying low.
module first_fit_heap_allocator_top
	import ffha_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output res_t result
);

	localparam int NGRAN = HEAP_BYTES / GRANULE_BYTES;
	localparam int AW    = $clog2(NGRAN);
	localparam int IW    = AW + 1;
	localparam int SW    = AW + 2;
	localparam int LG    = $clog2(GRANULE_BYTES);
	localparam int FBW   = $clog2(HEAP_BYTES + 1);
	localparam int NW    = (IW > REQ_W + 1) ? IW : REQ_W + 1;
	localparam int CW    = ((IW > OFFSET_W) ? IW : OFFSET_W) + 1;
	localparam logic [IW-1:0] NG = IW'(NGRAN);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_A_RD, S_A_CHK, S_A_REST, S_A_PREV, S_A_CUR,
		S_F_RDH, S_F_CHKH, S_F_RD, S_F_CHK, S_F_CHKC, S_F_H, S_F_PREV
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   clr_q;
	logic [IW-1:0]   head_q;
	logic [FBW-1:0]  bytes_q;
	logic [NW-1:0]   need_q;
	logic [IW-1:0]   cur_q;
	logic [AW-1:0]   prev_q;
	logic [IW-1:0]   prevlen_q;
	logic            has_prev_q;
	logic [SW-1:0]   steps_q;
	logic [AW-1:0]   h_q;
	logic [IW-1:0]   len_q;
	logic [IW-1:0]   link_q;
	logic [IW-1:0]   nxt_q;
	logic [IW-1:0]   rest_q;
	logic [IW-1:0]   restlen_q;
	logic [IW-1:0]   hlen_q;
	logic [IW-1:0]   hlink_q;
	logic            done_q;
	res_t            res_q;

	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [2*IW-1:0] wr_data;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic [2*IW-1:0] rd_data;
	logic [IW-1:0]   rd_link;
	logic [IW-1:0]   rd_len;

	assign rd_link = rd_data[2*IW-1:IW];
	assign rd_len  = rd_data[IW-1:0];

	ffha_mem #(.AW(AW), .DW(2 * IW)) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Request decode.
	logic [NW-1:0]  need_sum;
	logic [CW-1:0]  h_full;
	logic           off_bad;

	assign need_sum = NW'(req.request_bytes) + NW'(2 * GRANULE_BYTES - 1);
	assign h_full   = CW'(req.payload_offset >> LG) - CW'(1);
	assign off_bad  = (req.payload_offset[LG-1:0] != '0)
		|| (req.payload_offset < OFFSET_W'(GRANULE_BYTES))
		|| (h_full >= CW'(NGRAN));

	// Allocation fit and split decisions on the block just read.
	logic [IW-1:0]  need_iw;
	logic [IW-1:0]  diff;
	logic           fits;
	logic           split;

	assign need_iw = need_q[IW-1:0];
	assign fits    = NW'(rd_len) >= need_q;
	assign diff    = rd_len - need_iw;
	assign split   = (diff > IW'(SPLIT_MIN_GRANULES))
		&& (({1'b0, cur_q} + {1'b0, need_iw}) < {1'b0, NG});

	logic [IW+LG-1:0] goff;
	logic [FBW-1:0]   bytes_alloc;
	logic [FBW-1:0]   bytes_free;

	assign goff        = {cur_q + IW'(1), {LG{1'b0}}};
	assign bytes_alloc = bytes_q - FBW'({len_q, {LG{1'b0}}});
	assign bytes_free  = bytes_q + FBW'({len_q, {LG{1'b0}}});

	// Free-list walk decisions for a free.
	logic [IW:0] h_ext;
	logic        walk_more;
	logic        free_bad;
	logic        merge_right;
	logic        merge_left;

	assign h_ext       = {2'b00, h_q};
	assign walk_more   = ({1'b0, cur_q} < h_ext) && (steps_q <= SW'(NGRAN));
	assign free_bad    = (steps_q > SW'(NGRAN)) || ({1'b0, cur_q} == h_ext)
		|| (cur_q > NG)
		|| (has_prev_q && (({1'b0, prev_q} + {1'b0, prevlen_q}) > {1'b0, h_ext[IW-1:0]}))
		|| ((h_ext + {1'b0, len_q}) > {1'b0, cur_q});
	assign merge_right = (cur_q < NG) && ((h_ext + {1'b0, len_q}) == {1'b0, cur_q});
	assign merge_left  = ({1'b0, prev_q} + {1'b0, prevlen_q}) == h_ext;

	// Memory port steering.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_q[AW-1:0];
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = cur_q[AW-1:0];
		unique case (state_q)
			S_CLR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = (clr_q == '0) ? {NG, NG} : '0;
			end
			S_A_RD, S_F_RD: begin
				rd_en = 1'b1;
			end
			S_F_RDH: begin
				rd_en   = 1'b1;
				rd_addr = h_q;
			end
			S_A_REST: begin
				wr_en   = 1'b1;
				wr_addr = rest_q[AW-1:0];
				wr_data = {link_q, restlen_q};
			end
			S_A_PREV: begin
				wr_en   = has_prev_q;
				wr_addr = prev_q;
				wr_data = {nxt_q, prevlen_q};
			end
			S_A_CUR: begin
				wr_en   = 1'b1;
				wr_data = {IW'(0), len_q};
			end
			S_F_H: begin
				wr_en   = 1'b1;
				wr_addr = h_q;
				wr_data = {hlink_q, hlen_q};
			end
			S_F_PREV: begin
				wr_en   = has_prev_q;
				wr_addr = prev_q;
				wr_data = merge_left ? {hlink_q, prevlen_q + hlen_q}
					: {{1'b0, h_q}, prevlen_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_q      <= '0;
			head_q     <= '0;
			bytes_q    <= FBW'(HEAP_BYTES);
			has_prev_q <= 1'b0;
			steps_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NGRAN - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						cur_q      <= head_q;
						has_prev_q <= 1'b0;
						steps_q    <= '0;
						need_q     <= need_sum >> LG;
						h_q        <= h_full[AW-1:0];
						if (req.req_type == REQ_ALLOC) begin
							state_q <= S_A_RD;
						end else if (off_bad) begin
							res_q   <= '{ok: 1'b0, granted_offset: '0,
								free_bytes: FREE_W'(bytes_q)};
							done_q  <= 1'b1;
						end else begin
							state_q <= S_F_RDH;
						end
					end
				end
				S_A_RD: begin
					if (cur_q >= NG) begin
						res_q   <= '{ok: 1'b0, granted_offset: '0,
							free_bytes: FREE_W'(bytes_q)};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_A_CHK;
					end
				end
				S_A_CHK: begin
					if (steps_q > SW'(NGRAN)) begin
						res_q   <= '{ok: 1'b0, granted_offset: '0,
							free_bytes: FREE_W'(bytes_q)};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (fits) begin
						link_q    <= rd_link;
						rest_q    <= cur_q + need_iw;
						restlen_q <= diff;
						if (split) begin
							len_q   <= need_iw;
							nxt_q   <= cur_q + need_iw;
							state_q <= S_A_REST;
						end else begin
							len_q   <= rd_len;
							nxt_q   <= rd_link;
							state_q <= S_A_PREV;
						end
					end else begin
						prev_q     <= cur_q[AW-1:0];
						prevlen_q  <= rd_len;
						has_prev_q <= 1'b1;
						cur_q      <= rd_link;
						steps_q    <= steps_q + SW'(1);
						state_q    <= S_A_RD;
					end
				end
				S_A_REST: begin
					state_q <= S_A_PREV;
				end
				S_A_PREV: begin
					if (!has_prev_q) begin
						head_q <= nxt_q;
					end
					state_q <= S_A_CUR;
				end
				S_A_CUR: begin
					bytes_q <= bytes_alloc;
					res_q   <= '{ok: 1'b1, granted_offset: OFFSET_W'(goff),
						free_bytes: FREE_W'(bytes_alloc)};
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_F_RDH: begin
					state_q <= S_F_CHKH;
				end
				S_F_CHKH: begin
					if ((rd_len == '0) || (rd_len > (NG - {1'b0, h_q}))) begin
						res_q   <= '{ok: 1'b0, granted_offset: '0,
							free_bytes: FREE_W'(bytes_q)};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						len_q   <= rd_len;
						state_q <= S_F_RD;
					end
				end
				S_F_RD: begin
					// The read of the current block is issued here in every case.
					if (walk_more) begin
						state_q <= S_F_CHK;
					end else if (free_bad) begin
						res_q   <= '{ok: 1'b0, granted_offset: '0,
							free_bytes: FREE_W'(bytes_q)};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (merge_right) begin
						state_q <= S_F_CHKC;
					end else begin
						hlen_q  <= len_q;
						hlink_q <= cur_q;
						state_q <= S_F_H;
					end
				end
				S_F_CHK: begin
					prev_q     <= cur_q[AW-1:0];
					prevlen_q  <= rd_len;
					has_prev_q <= 1'b1;
					cur_q      <= rd_link;
					steps_q    <= steps_q + SW'(1);
					state_q    <= S_F_RD;
				end
				S_F_CHKC: begin
					hlen_q  <= len_q + rd_len;
					hlink_q <= rd_link;
					state_q <= S_F_H;
				end
				S_F_H: begin
					bytes_q <= bytes_free;
					if (!has_prev_q) begin
						head_q <= {1'b0, h_q};
					end
					state_q <= S_F_PREV;
				end
				S_F_PREV: begin
					res_q   <= '{ok: 1'b1, granted_offset: '0,
						free_bytes: FREE_W'(bytes_q)};
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule
